### rtl/stereo_zero_cross_gate_macros.svh
// Assertion helpers used by the checker in rtl/szc_checker.sv.
`ifndef STEREO_ZERO_CROSS_GATE_MACROS_SVH
`define STEREO_ZERO_CROSS_GATE_MACROS_SVH

// Checked only while reset is low.
`define SZC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Checked at every edge, reset cycles included.
`define SZC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

### rtl/szc_pkg.sv
`timescale 1ns / 1ps
package szc_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int THR_W      = 23;
   localparam int REL_W      = 20;
   localparam int WET_W      = 17;
   localparam int CNT_W      = 13;
   localparam int ROLL_W     = 33;
   localparam int GATE_FRAC  = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [CNT_W-1:0] COUNT_CAP = 13'd6000;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_MIX   = 2'd2;

   localparam logic [THR_W-1:0] THRESHOLD_RST = 23'd1510;
   localparam logic [REL_W-1:0] RELEASE_RST   = 20'd6711;
   localparam logic [WET_W-1:0] WET_MIX_RST   = 17'd65536;

   // One datapath step per cycle; a channel runs OP_UPD through OP_MIX.
   typedef enum logic [3:0] {
      OP_UPD,   // count, flag and roller update, latch sample
      OP_SQ,    // t*t, clip roller to gate
      OP_H0,    // Horner start
      OP_H1,
      OP_H2,
      OP_H3,
      OP_H4,
      OP_BR,    // bridge * (1 - g)
      OP_XG,    // x * g
      OP_SUM,   // combine, round, saturate
      OP_GATE,  // force to zero when gate closed and quiet
      OP_MW,    // y * wet
      OP_MD,    // x * dry
      OP_MIX    // round, saturate, store channel result
   } szc_op_type;

   typedef struct packed {
      logic       load;     // input transfer this cycle
      logic       run;      // op is valid
      szc_op_type op;
      logic       chan;     // 0 left, 1 right
      logic       publish;  // move results to the output register
   } szc_cmd_type;

endpackage

### rtl/szc_ctrl.sv
`timescale 1ns / 1ps
module szc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_stall,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output szc_pkg::szc_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_PUB
   } state_type;

   state_type           state_ff;
   szc_pkg::szc_op_type op_ff;
   logic                chan_ff;
   logic                rsp_valid_ff;
   logic                accept;
   logic                out_free;

   function automatic szc_pkg::szc_op_type next_op(input szc_pkg::szc_op_type op);
      unique case (op)
         szc_pkg::OP_UPD:  next_op = szc_pkg::OP_SQ;
         szc_pkg::OP_SQ:   next_op = szc_pkg::OP_H0;
         szc_pkg::OP_H0:   next_op = szc_pkg::OP_H1;
         szc_pkg::OP_H1:   next_op = szc_pkg::OP_H2;
         szc_pkg::OP_H2:   next_op = szc_pkg::OP_H3;
         szc_pkg::OP_H3:   next_op = szc_pkg::OP_H4;
         szc_pkg::OP_H4:   next_op = szc_pkg::OP_BR;
         szc_pkg::OP_BR:   next_op = szc_pkg::OP_XG;
         szc_pkg::OP_XG:   next_op = szc_pkg::OP_SUM;
         szc_pkg::OP_SUM:  next_op = szc_pkg::OP_GATE;
         szc_pkg::OP_GATE: next_op = szc_pkg::OP_MW;
         szc_pkg::OP_MW:   next_op = szc_pkg::OP_MD;
         szc_pkg::OP_MD:   next_op = szc_pkg::OP_MIX;
         default:          next_op = szc_pkg::OP_UPD;
      endcase
   endfunction

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= szc_pkg::OP_UPD;
         chan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_PUB) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RUN;
                  op_ff    <= szc_pkg::OP_UPD;
                  chan_ff  <= 1'b0;
               end
            end
            ST_RUN: begin
               if (op_ff == szc_pkg::OP_MIX) begin
                  op_ff <= szc_pkg::OP_UPD;
                  if (chan_ff) begin
                     state_ff <= ST_PUB;
                  end else begin
                     chan_ff <= 1'b1;
                  end
               end else begin
                  op_ff <= next_op(op_ff);
               end
            end
            ST_PUB: begin
               // wait here while the previous result is still stalled
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.load    = accept;
   assign cmd.run     = (state_ff == ST_RUN);
   assign cmd.op      = op_ff;
   assign cmd.chan    = chan_ff;
   assign cmd.publish = (state_ff == ST_PUB) && out_free;

endmodule

### rtl/szc_dp.sv
`timescale 1ns / 1ps
module szc_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  szc_pkg::szc_cmd_type                  cmd,
   input  logic                                  csr_we,
   input  logic        [szc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [szc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic signed [szc_pkg::SAMPLE_W-1:0]   req_sample_left,
   input  logic signed [szc_pkg::SAMPLE_W-1:0]   req_sample_right,
   output logic signed [szc_pkg::SAMPLE_W-1:0]   rsp_out_left,
   output logic signed [szc_pkg::SAMPLE_W-1:0]   rsp_out_right
);

   // Taylor coefficients of 1 - cos in Q0.30, highest order first
   localparam logic signed [31:0] C10 = 32'sd296;
   localparam logic signed [31:0] C8  = 32'sd26631;
   localparam logic signed [31:0] C6  = 32'sd1491308;
   localparam logic signed [31:0] C4  = 32'sd44739243;
   localparam logic signed [31:0] C2  = 32'sd536870912;

   localparam logic [szc_pkg::GATE_FRAC:0] ONE_G = 21'd1 << szc_pkg::GATE_FRAC;

   // configuration
   logic [szc_pkg::THR_W-1:0] thr_ff;
   logic [szc_pkg::REL_W-1:0] rel_ff;
   logic [szc_pkg::WET_W-1:0] wet_ff;

   // per channel state
   logic                       flag_ff [2];
   logic [szc_pkg::CNT_W-1:0]  cnt_ff  [2];
   logic [szc_pkg::ROLL_W-1:0] roll_ff [2];

   // working registers
   logic signed [szc_pkg::SAMPLE_W-1:0] x_left_ff, x_right_ff;
   logic signed [szc_pkg::SAMPLE_W-1:0] x_ff;
   logic        [szc_pkg::SAMPLE_W-1:0] mag_ff;
   logic                                pos_ff;
   logic        [szc_pkg::GATE_FRAC:0]  g_ff;
   logic signed [31:0]                  u_ff;
   logic signed [63:0]                  prod_ff;
   logic        [42:0]                  term_ff;
   logic signed [szc_pkg::SAMPLE_W-1:0] y_ff;
   logic signed [41:0]                  dry_ff;
   logic signed [szc_pkg::SAMPLE_W-1:0] res_left_ff, res_right_ff;
   logic signed [szc_pkg::SAMPLE_W-1:0] out_left_ff, out_right_ff;

   // update step
   logic signed [szc_pkg::SAMPLE_W-1:0] x_sel;
   logic                                pos_c;
   logic        [szc_pkg::SAMPLE_W-1:0] mag_c;
   logic        [szc_pkg::CNT_W:0]      cnt_step;
   logic        [szc_pkg::CNT_W-1:0]    cnt_new;
   logic                                loud;
   logic        [szc_pkg::ROLL_W-1:0]   roll_cur;
   logic        [szc_pkg::ROLL_W-1:0]   target;
   logic        [szc_pkg::ROLL_W-1:0]   roll_new;
   logic        [szc_pkg::GATE_FRAC:0]  g_c;

   // multiplier and the rest
   logic signed [31:0]                  hi30;
   logic signed [31:0]                  coef;
   logic signed [31:0]                  bridge_sum;
   logic        [24:0]                  bridge;
   logic        [szc_pkg::GATE_FRAC:0]  one_minus_g;
   logic        [szc_pkg::WET_W-1:0]    w_eff;
   logic        [szc_pkg::WET_W-1:0]    w_dry;
   logic signed [31:0]                  mul_a, mul_b;
   logic signed [63:0]                  mul_res;
   logic signed [45:0]                  sterm;
   logic signed [45:0]                  v_sum;
   logic signed [szc_pkg::SAMPLE_W-1:0] y_sat;
   logic        [szc_pkg::SAMPLE_W-1:0] abs_y;
   logic        [25:0]                  three_y;
   logic signed [41:0]                  mix_sum;
   logic signed [szc_pkg::SAMPLE_W-1:0] mix_sat;

   function automatic logic signed [szc_pkg::SAMPLE_W-1:0] sat24(input logic signed [25:0] v);
      if (v > 26'sd8388607) begin
         sat24 = 24'sh7FFFFF;
      end else if (v < -26'sd8388608) begin
         sat24 = 24'sh800000;
      end else begin
         sat24 = v[23:0];
      end
   endfunction

   // ---- update step ----
   assign x_sel    = cmd.chan ? x_right_ff : x_left_ff;
   assign pos_c    = ~x_sel[szc_pkg::SAMPLE_W-1];
   assign mag_c    = pos_c ? x_sel : -x_sel;
   assign roll_cur = roll_ff[cmd.chan];

   always_comb begin
      if (pos_c) begin
         cnt_step = flag_ff[cmd.chan] ? '0 : {1'b0, cnt_ff[cmd.chan]};
      end else begin
         cnt_step = {1'b0, cnt_ff[cmd.chan]} + 14'd1;
      end
      if (cnt_step > {1'b0, szc_pkg::COUNT_CAP}) begin
         cnt_new = szc_pkg::COUNT_CAP;
      end else begin
         cnt_new = cnt_step[szc_pkg::CNT_W-1:0];
      end
   end

   assign loud   = mag_c > {1'b0, thr_ff};
   assign target = {cnt_new, {szc_pkg::GATE_FRAC{1'b0}}};

   always_comb begin
      if (loud) begin
         roll_new = (roll_cur < target) ? target : roll_cur;
      end else if (roll_cur > {13'd0, rel_ff}) begin
         roll_new = roll_cur - {13'd0, rel_ff};
      end else begin
         roll_new = '0;
      end
   end

   assign g_c = (|roll_cur[szc_pkg::ROLL_W-1:szc_pkg::GATE_FRAC]) ? ONE_G
                : {1'b0, roll_cur[szc_pkg::GATE_FRAC-1:0]};

   // ---- shared multiplier ----
   assign hi30        = $signed(prod_ff[61:30]);
   assign bridge_sum  = hi30 + 32'sd64;
   assign bridge      = bridge_sum[31:7];
   assign one_minus_g = ONE_G - g_ff;
   assign w_eff       = (wet_ff[16] && (|wet_ff[15:0])) ? 17'd65536 : wet_ff;
   assign w_dry       = 17'd65536 - w_eff;

   always_comb begin
      unique case (cmd.op)
         szc_pkg::OP_H1: coef = C8;
         szc_pkg::OP_H2: coef = C6;
         szc_pkg::OP_H3: coef = C4;
         default:        coef = C2;
      endcase
   end

   always_comb begin
      unique case (cmd.op)
         szc_pkg::OP_SQ: begin
            mul_a = {1'b0, mag_ff, 7'd0};
            mul_b = {1'b0, mag_ff, 7'd0};
         end
         szc_pkg::OP_H0: begin
            mul_a = hi30;
            mul_b = C10;
         end
         szc_pkg::OP_H1, szc_pkg::OP_H2, szc_pkg::OP_H3, szc_pkg::OP_H4: begin
            mul_a = u_ff;
            mul_b = coef - hi30;
         end
         szc_pkg::OP_BR: begin
            mul_a = {7'd0, bridge};
            mul_b = {11'd0, one_minus_g};
         end
         szc_pkg::OP_XG: begin
            mul_a = {{8{x_ff[szc_pkg::SAMPLE_W-1]}}, x_ff};
            mul_b = {11'd0, g_ff};
         end
         szc_pkg::OP_MW: begin
            mul_a = {{8{y_ff[szc_pkg::SAMPLE_W-1]}}, y_ff};
            mul_b = {15'd0, w_eff};
         end
         default: begin
            mul_a = {{8{x_ff[szc_pkg::SAMPLE_W-1]}}, x_ff};
            mul_b = {15'd0, w_dry};
         end
      endcase
   end

   assign mul_res = mul_a * mul_b;

   // ---- combine, gate, mix ----
   assign sterm   = {3'd0, term_ff};
   assign v_sum   = $signed(prod_ff[45:0]) + (pos_ff ? sterm : -sterm) + 46'sd524288;
   assign y_sat   = sat24(v_sum[45:20]);
   assign abs_y   = y_ff[szc_pkg::SAMPLE_W-1] ? -y_ff : y_ff;
   assign three_y = {2'd0, abs_y} + {1'b0, abs_y, 1'b0};
   assign mix_sum = $signed(prod_ff[41:0]) + dry_ff + 42'sd32768;
   assign mix_sat = sat24(mix_sum[41:16]);

   // control state: configuration and channel trackers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= szc_pkg::THRESHOLD_RST;
         rel_ff     <= szc_pkg::RELEASE_RST;
         wet_ff     <= szc_pkg::WET_MIX_RST;
         flag_ff[0] <= 1'b0;
         flag_ff[1] <= 1'b0;
         cnt_ff[0]  <= '0;
         cnt_ff[1]  <= '0;
         roll_ff[0] <= '0;
         roll_ff[1] <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               szc_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata[szc_pkg::THR_W-1:0];
               szc_pkg::CSR_RELEASE:   rel_ff <= csr_wdata[szc_pkg::REL_W-1:0];
               szc_pkg::CSR_WET_MIX:   wet_ff <= csr_wdata[szc_pkg::WET_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.run && (cmd.op == szc_pkg::OP_UPD)) begin
            flag_ff[cmd.chan] <= ~pos_c;
            cnt_ff[cmd.chan]  <= cnt_new;
            roll_ff[cmd.chan] <= roll_new;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_left_ff  <= req_sample_left;
         x_right_ff <= req_sample_right;
      end
      if (cmd.publish) begin
         out_left_ff  <= res_left_ff;
         out_right_ff <= res_right_ff;
      end
      if (cmd.run) begin
         unique case (cmd.op)
            szc_pkg::OP_UPD: begin
               x_ff   <= x_sel;
               mag_ff <= mag_c;
               pos_ff <= pos_c;
            end
            szc_pkg::OP_SQ: begin
               g_ff    <= g_c;
               prod_ff <= mul_res;
            end
            szc_pkg::OP_H0: begin
               u_ff    <= hi30;
               prod_ff <= mul_res;
            end
            szc_pkg::OP_H1, szc_pkg::OP_H2, szc_pkg::OP_H3, szc_pkg::OP_H4,
            szc_pkg::OP_BR, szc_pkg::OP_MW: begin
               prod_ff <= mul_res;
            end
            szc_pkg::OP_XG: begin
               term_ff <= prod_ff[42:0];
               prod_ff <= mul_res;
            end
            szc_pkg::OP_SUM: begin
               y_ff <= y_sat;
            end
            szc_pkg::OP_GATE: begin
               if ((g_ff == '0) && (three_y < {3'd0, thr_ff})) begin
                  y_ff <= '0;
               end
            end
            szc_pkg::OP_MD: begin
               dry_ff  <= $signed(prod_ff[41:0]);
               prod_ff <= mul_res;
            end
            default: begin
               if (cmd.chan) begin
                  res_right_ff <= mix_sat;
               end else begin
                  res_left_ff <= mix_sat;
               end
            end
         endcase
      end
   end

   assign rsp_out_left  = out_left_ff;
   assign rsp_out_right = out_right_ff;

endmodule

### rtl/stereo_zero_cross_gate.sv
`timescale 1ns / 1ps
// channel   direction   handshake               payload
// req       in          req_valid / req_stall   req_sample_left, req_sample_right
// rsp       out         rsp_valid / rsp_stall   rsp_out_left, rsp_out_right
// csr       in          csr_we                  csr_index, csr_wdata
//
// 14 steps per channel through one shared 32x32 multiplier, left then right,
// then a publish state loads the output register; a new pair transfers only
// once the last one has been published and the block is idle again.
// Synchronous active-high reset clears the channel trackers and loads defaults.
// req_stall is high while a pair is in work; a stalled result holds the
// finished pair until the output register frees up.
module stereo_zero_cross_gate (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [szc_pkg::SAMPLE_W-1:0]   req_sample_left,
   input  logic signed [szc_pkg::SAMPLE_W-1:0]   req_sample_right,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [szc_pkg::SAMPLE_W-1:0]   rsp_out_left,
   output logic signed [szc_pkg::SAMPLE_W-1:0]   rsp_out_right,
   input  logic                                  csr_we,
   input  logic        [szc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [szc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   szc_pkg::szc_cmd_type cmd;

   szc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   szc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right)
   );

endmodule

### rtl/szc_checker.sv
`timescale 1ns / 1ps
`include "stereo_zero_cross_gate_macros.svh"
module szc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [szc_pkg::SAMPLE_W-1:0] rsp_out_left,
   input logic signed [szc_pkg::SAMPLE_W-1:0] rsp_out_right
);

   // a held result stays offered and unchanged
   `SZC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `SZC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_out_left) && $stable(rsp_out_right))

   // a transfer makes the block busy
   `SZC_ASSERT(a_busy_after_take, clock, reset, req_valid && !req_stall |=> req_stall)

   // a new result only shows up at the end of a busy period
   `SZC_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall))

   `SZC_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind stereo_zero_cross_gate szc_checker u_szc_checker (.*);

### sim/szc_gate_checker.sv
`timescale 1ns / 1ps
module szc_gate_checker
   import szc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_sample_left,
   input  logic signed [SAMPLE_W-1:0]   req_sample_right,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [SAMPLE_W-1:0]   rsp_out_left,
   input  logic signed [SAMPLE_W-1:0]   rsp_out_right,
   input  logic                         csr_we,
   input  logic        [CSR_IDX_W-1:0]  csr_index,
   input  logic        [CSR_DATA_W-1:0] csr_wdata,
   input  logic                         drain_check,
   output int                           fail_count,
   output int                           pairs_pending
);

   localparam longint GATE_ONE   = longint'(1) << GATE_FRAC;
   localparam longint FULL_WET   = 65536;
   localparam longint Q23_MAX    = 8388607;
   localparam longint Q23_MIN    = -8388608;

   typedef struct {
      logic signed [SAMPLE_W-1:0] l_out;
      logic signed [SAMPLE_W-1:0] r_out;
   } stereo_pair_type;

   typedef struct {
      bit              negative;
      bit [CNT_W-1:0]  quiet;
      bit [ROLL_W-1:0] roller;
   } chan_track_type;

   chan_track_type  track [2];
   bit [THR_W-1:0]  thr_cfg;
   bit [REL_W-1:0]  rel_cfg;
   bit [WET_W-1:0]  wet_cfg;
   stereo_pair_type expected_pairs [$];
   stereo_pair_type want;
   int              mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $time, what);
      mismatches++;
   endtask

   // 1 - cos(m / 2^23) in Q0.23 via truncated Horner Taylor series in Q0.30
   function automatic longint unsigned one_minus_cos_q23(input longint unsigned m);
      longint unsigned t;
      longint unsigned u;
      longint unsigned a;
      longint unsigned r;
      t = m << 7;
      u = (t * t) >> 30;
      a = 296;
      a = 26631 - ((u * a) >> 30);
      a = 1491308 - ((u * a) >> 30);
      a = 44739243 - ((u * a) >> 30);
      a = 536870912 - ((u * a) >> 30);
      r = (u * a) >> 30;
      return (r + 64) >> 7;
   endfunction

   // round half toward +inf
   function automatic longint round_half_up(input longint v, input int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_q23(input longint v);
      if (v > Q23_MAX) return Q23_MAX;
      if (v < Q23_MIN) return Q23_MIN;
      return v;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] gate_sample(
      input int                         ch,
      input logic signed [SAMPLE_W-1:0] sample
   );
      longint x;
      longint mag;
      longint target;
      longint g;
      longint bridge;
      longint term;
      longint v;
      longint y;
      longint ay;
      longint w;
      longint mix;
      bit     positive;
      x = sample;
      positive = (x >= 0);   // zero counts as positive
      mag = positive ? x : -x;

      if (positive) begin
         if (track[ch].negative)
            track[ch].quiet = '0;
         track[ch].negative = 1'b0;
      end else begin
         track[ch].quiet = track[ch].quiet + 1'b1;
         track[ch].negative = 1'b1;
      end
      if (track[ch].quiet > COUNT_CAP)
         track[ch].quiet = COUNT_CAP;

      if (mag > longint'(thr_cfg)) begin
         target = longint'(track[ch].quiet) << GATE_FRAC;
         if (longint'(track[ch].roller) < target)
            track[ch].roller = ROLL_W'(target);
      end else if (track[ch].roller > rel_cfg) begin
         track[ch].roller = track[ch].roller - rel_cfg;
      end else begin
         track[ch].roller = '0;
      end

      g = (longint'(track[ch].roller) < GATE_ONE) ? longint'(track[ch].roller) : GATE_ONE;
      bridge = longint'(one_minus_cos_q23(longint'(mag)));
      term = bridge * (GATE_ONE - g);
      v = x * g + (positive ? term : -term);
      y = clamp_q23(round_half_up(v, GATE_FRAC));

      if (g == 0) begin
         ay = (y < 0) ? -y : y;
         if (3 * ay < longint'(thr_cfg))
            y = 0;
      end

      w = (longint'(wet_cfg) > FULL_WET) ? FULL_WET : longint'(wet_cfg);
      mix = y * w + x * (FULL_WET - w);
      return SAMPLE_W'(clamp_q23(round_half_up(mix, 16)));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         thr_cfg = THRESHOLD_RST;
         rel_cfg = RELEASE_RST;
         wet_cfg = WET_MIX_RST;
         for (int ch = 0; ch < 2; ch++) begin
            track[ch].negative = 1'b0;
            track[ch].quiet = '0;
            track[ch].roller = '0;
         end
         expected_pairs.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: thr_cfg = csr_wdata[THR_W-1:0];
               CSR_RELEASE:   rel_cfg = csr_wdata[REL_W-1:0];
               CSR_WET_MIX:   wet_cfg = csr_wdata[WET_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d / %0d",
                                         rsp_out_left, rsp_out_right));
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_out_left !== want.l_out)
                  report_mismatch($sformatf("out_left %0d, expected %0d",
                                            rsp_out_left, want.l_out));
               if (rsp_out_right !== want.r_out)
                  report_mismatch($sformatf("out_right %0d, expected %0d",
                                            rsp_out_right, want.r_out));
            end
         end

         if (req_valid && !req_stall) begin
            want.l_out = gate_sample(0, req_sample_left);
            want.r_out = gate_sample(1, req_sample_right);
            expected_pairs.push_back(want);
         end

         if (drain_check && expected_pairs.size() != 0)
            report_mismatch($sformatf("%0d gated pairs never came out",
                                      expected_pairs.size()));
      end
      pairs_pending <= expected_pairs.size();
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import szc_pkg::*;

   localparam int Q23_MAX_MAG = 8388608;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [SAMPLE_W-1:0]   req_sample_left = '0;
   logic signed [SAMPLE_W-1:0]   req_sample_right = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_out_left;
   logic signed [SAMPLE_W-1:0]   rsp_out_right;
   logic                         csr_we = 1'b0;
   logic        [CSR_IDX_W-1:0]  csr_index = CSR_THRESHOLD;
   logic        [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                         drain_check = 1'b0;
   int                           fail_count;
   int                           pairs_pending;

   bit          idle_on = 1'b1;
   int unsigned cur_threshold = THRESHOLD_RST;
   bit          run_neg [2] = '{1'b0, 1'b1};
   int          run_len [2] = '{0, 0};

   // extremes, threshold edges, zero after negatives, gate open then release
   int directed_pairs [16][2] = '{
      '{0, 0}, '{8388607, -8388608}, '{-8388608, 8388607}, '{-1, 1}, '{1, -1},
      '{1510, -1510}, '{1511, -1511}, '{-400000, -400000}, '{-400000, 300},
      '{-5000, -7000}, '{0, 0}, '{2000000, -2000000}, '{100, -100}, '{-3, 3},
      '{0, -8388608}, '{8388607, 0}
   };

   stereo_zero_cross_gate DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   szc_gate_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .drain_check      (drain_check),
      .fail_count       (fail_count),
      .pairs_pending    (pairs_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 9);
   end

   task automatic send_pair(input logic signed [SAMPLE_W-1:0] l_smp,
                            input logic signed [SAMPLE_W-1:0] r_smp);
      while (idle_on && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_left <= l_smp;
      req_sample_right <= r_smp;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic drain_pairs();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pairs_pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int unsigned thr, input int unsigned rel,
                             input int unsigned wet);
      drain_pairs();
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_RELEASE, rel);
      write_reg(CSR_WET_MIX, wet);
      cur_threshold = thr;
   endtask

   // magnitude in 0..2^23, biased toward zero, the threshold and full scale
   function automatic int pick_mag();
      int m;
      case ($urandom_range(0, 9))
         0, 1, 2: m = $urandom_range(0, 6);
         3, 4, 5: begin
            m = int'(cur_threshold) + int'($urandom_range(0, 8)) - 4;
            if (m < 0) m = 0;
            if (m > Q23_MAX_MAG) m = Q23_MAX_MAG;
         end
         6, 7, 8: m = $urandom_range(0, Q23_MAX_MAG);
         default: m = Q23_MAX_MAG;
      endcase
      return m;
   endfunction

   // runs of same-sign samples, so zero crossings come at varied spacing
   function automatic logic signed [SAMPLE_W-1:0] shaped_sample(input int ch);
      int m;
      int s;
      if (run_len[ch] == 0) begin
         if ($urandom_range(0, 3) != 0)
            run_neg[ch] = !run_neg[ch];
         run_len[ch] = $urandom_range(1, 10);
      end
      run_len[ch]--;
      m = pick_mag();
      if (run_neg[ch])
         s = -m;
      else
         s = (m > Q23_MAX_MAG - 1) ? Q23_MAX_MAG - 1 : m;
      return SAMPLE_W'(s);
   endfunction

   task automatic run_random(input int n_pairs);
      for (int i = 0; i < n_pairs; i++) begin
         if ($urandom_range(0, 99) < 15)
            send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
         else
            send_pair(shaped_sample(0), shaped_sample(1));
      end
   endtask

   // long negative run on the left, loud now and then, so the roller is
   // raised to counts well above one before it has to release
   task automatic quiet_run();
      int s;
      for (int i = 0; i < 60; i++) begin
         if (i % 20 == 19)
            s = -int'($urandom_range(2000, Q23_MAX_MAG));
         else
            s = -int'($urandom_range(1, 1400));
         send_pair(SAMPLE_W'(s), shaped_sample(1));
      end
      send_pair(-24'sd3000000, shaped_sample(1));
      send_pair(24'sd5000000, shaped_sample(1));
      for (int i = 0; i < 6; i++)
         send_pair(SAMPLE_W'($urandom_range(0, 1000)), shaped_sample(1));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 16; i++)
         send_pair(SAMPLE_W'(directed_pairs[i][0]), SAMPLE_W'(directed_pairs[i][1]));

      set_config(0, 1048575, 0);
      send_pair(24'sd0, 24'sd0);
      send_pair(24'sd1, -24'sd1);
      send_pair(-24'sd8388608, 24'sd8388607);

      set_config(THRESHOLD_RST, RELEASE_RST, WET_MIX_RST);
      quiet_run();

      set_config($urandom_range(0, 40000), $urandom_range(0, 100000),
                 $urandom_range(0, 65536));
      run_random(90);
      set_config(8388607, 0, 65536);
      run_random(90);
      idle_on <= 1'b0;
      set_config(0, 1048575, 0);
      run_random(90);
      idle_on <= 1'b1;
      set_config($urandom_range(0, 5000), 1048575, 131071);
      run_random(90);
      set_config(THRESHOLD_RST, 1, 32768);
      run_random(90);

      drain_pairs();
      repeat (40) @(posedge clock);
      drain_check <= 1'b1;
      @(posedge clock);
      drain_check <= 1'b0;
      @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
